/* hdl/ple_pkg.sv */
// Package for the positional list engine: operation and status codes,
// scan modes and the command/status structs between controller and datapath.
// No dependencies.
package ple_pkg;

    // Default list capacity.
    localparam int DEPTH_DEFAULT = 64;

    // Operation codes.
    localparam logic [2:0] FUNC_CLEAR  = 3'd0;
    localparam logic [2:0] FUNC_APPEND = 3'd1;
    localparam logic [2:0] FUNC_READ   = 3'd2;
    localparam logic [2:0] FUNC_FIND   = 3'd3;
    localparam logic [2:0] FUNC_INSERT = 3'd4;
    localparam logic [2:0] FUNC_DELETE = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Scan modes of the datapath walker.
    localparam logic [1:0] SCAN_FIND = 2'd0;
    localparam logic [1:0] SCAN_READ = 2'd1;
    localparam logic [1:0] SCAN_UP   = 2'd2;
    localparam logic [1:0] SCAN_DOWN = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       count_clr;
        logic       count_inc;
        logic       count_dec;
        logic       app_write;
        logic       ins_write;
        logic       scan_start;
        logic [1:0] scan_mode;
        logic       scan_en;
        logic       out_load;
        logic [2:0] status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] func;
        logic       empty;
        logic       full;
        logic       bad_rd;
        logic       bad_ins;
        logic       scan_done;
        logic       found;
    } stat_t;

endpackage

/* hdl/ple_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/ple_ctrl.sv */
// Controller state machine of the positional list engine.
// Depends on ple_pkg for codes and the command/status structs.
module ple_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output ple_pkg::cmd_t cmd,
    input  ple_pkg::stat_t stat
);
    import ple_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_INSW   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] code_reg, code_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.status = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                code_next  = ST_OK;
                state_next = S_FINISH;
                case (stat.func)
                    FUNC_CLEAR: begin
                        cmd.count_clr = 1'b1;
                    end
                    FUNC_APPEND: begin
                        if (stat.full) begin
                            code_next = ST_FULL;
                        end else begin
                            cmd.app_write = 1'b1;
                            cmd.count_inc = 1'b1;
                        end
                    end
                    FUNC_READ: begin
                        if (stat.empty) begin
                            code_next = ST_EMPTY;
                        end else if (stat.bad_rd) begin
                            code_next = ST_BADPOS;
                        end else begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = SCAN_READ;
                            state_next     = S_SCAN;
                        end
                    end
                    FUNC_FIND: begin
                        if (stat.empty) begin
                            code_next = ST_EMPTY;
                        end else begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = SCAN_FIND;
                            state_next     = S_SCAN;
                        end
                    end
                    FUNC_INSERT: begin
                        if (stat.bad_ins) begin
                            code_next = ST_BADPOS;
                        end else if (stat.full) begin
                            code_next = ST_FULL;
                        end else begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = SCAN_UP;
                            state_next     = S_SCAN;
                        end
                    end
                    FUNC_DELETE: begin
                        if (stat.empty) begin
                            code_next = ST_EMPTY;
                        end else if (stat.bad_rd) begin
                            code_next = ST_BADPOS;
                        end else begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = SCAN_DOWN;
                            state_next     = S_SCAN;
                        end
                    end
                    default: begin
                        code_next = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_FINISH;
                    if (stat.func == FUNC_FIND) begin
                        code_next = stat.found ? ST_OK : ST_NOTFOUND;
                    end
                    if (stat.func == FUNC_INSERT) begin
                        state_next = S_INSW;
                    end
                    if (stat.func == FUNC_DELETE) begin
                        cmd.count_dec = 1'b1;
                    end
                end
            end
            S_INSW: begin
                cmd.ins_write = 1'b1;
                cmd.count_inc = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            code_reg    <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            code_reg    <= code_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // An accepted word is always decoded in the next cycle.
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECODE))
        else $error("accepted word not decoded");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while stalled");

endmodule

/* hdl/ple_dpath.sv */
// Datapath of the positional list engine: entry store, length counter,
// walker that reads, searches and shifts entries, and the output registers.
// Depends on ple_pkg and ple_ram.
module ple_dpath #(
    parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [2:0]          s_func,
    input  logic [6:0]          s_position,
    input  logic signed [31:0]  s_value,
    output logic [2:0]          m_status,
    output logic signed [31:0]  m_result_value,
    output logic [6:0]          m_found_position,
    output logic [6:0]          m_list_length,
    input  ple_pkg::cmd_t       cmd,
    output ple_pkg::stat_t      stat
);
    import ple_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

    // Captured input word.
    logic [2:0]         func_reg;
    logic [6:0]         pos_reg;
    logic signed [31:0] value_reg;

    // List length.
    logic [CW-1:0]      count_reg, count_next;

    // Walker state.
    logic [AW-1:0]      idx_reg, pend_idx_reg, base_idx_reg;
    logic [CW-1:0]      rem_reg;
    logic               pend_reg;
    logic [1:0]         mode_reg;

    // Result fields.
    logic signed [31:0] rval_reg;
    logic [6:0]         fpos_reg;
    logic [2:0]         m_status_reg;
    logic signed [31:0] m_result_value_reg;
    logic [6:0]         m_found_position_reg;
    logic [6:0]         m_list_length_reg;

    // Entry store ports.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;

    // Widened operands for position checks.
    logic [CMPW-1:0]    pos_ext, cnt_ext, pos_m1, shift_len, fpos_ext, len_ext;
    logic               match, hit, capture;

    assign pos_ext   = CMPW'(pos_reg);
    assign cnt_ext   = CMPW'(count_reg);
    assign pos_m1    = pos_ext - CMPW'(1);
    assign shift_len = cnt_ext - pos_m1;
    assign fpos_ext  = CMPW'(pend_idx_reg) + CMPW'(1);
    assign len_ext   = CMPW'(count_reg);

    // Search compare and early stop on the first hit.
    assign match   = (ram_rdata == value_reg);
    assign hit     = (mode_reg == SCAN_FIND) && pend_reg && match;
    assign capture = pend_reg && ((mode_reg == SCAN_READ) ||
                     ((mode_reg == SCAN_DOWN) && (pend_idx_reg == base_idx_reg)));

    // Status to the controller.
    always_comb begin
        stat.func      = func_reg;
        stat.empty     = (count_reg == '0);
        stat.full      = (cnt_ext >= CMPW'(DEPTH));
        stat.bad_rd    = (pos_reg == '0) || (pos_ext > cnt_ext);
        stat.bad_ins   = (pos_reg == '0) || (pos_ext > cnt_ext + CMPW'(1));
        stat.scan_done = ((rem_reg == '0) && !pend_reg) || hit;
        stat.found     = hit;
    end

    // Store write port: append, final insert write, or a shifted entry.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = value_reg;
        if (cmd.app_write) begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[AW-1:0];
        end else if (cmd.ins_write) begin
            ram_we    = 1'b1;
            ram_waddr = pos_m1[AW-1:0];
        end else if (cmd.scan_en && pend_reg) begin
            ram_wdata = ram_rdata;
            if (mode_reg == SCAN_UP) begin
                ram_we    = 1'b1;
                ram_waddr = pend_idx_reg + AW'(1);
            end else if ((mode_reg == SCAN_DOWN) && (pend_idx_reg != base_idx_reg)) begin
                ram_we    = 1'b1;
                ram_waddr = pend_idx_reg - AW'(1);
            end
        end
    end

    ple_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    // Length counter.
    always_comb begin
        count_next = count_reg;
        if (cmd.count_clr) begin
            count_next = '0;
        end else if (cmd.count_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.count_dec) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            rem_reg   <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.scan_start) begin
                pend_reg <= 1'b0;
                if ((cmd.scan_mode == SCAN_FIND)) begin
                    rem_reg <= count_reg;
                end else if (cmd.scan_mode == SCAN_READ) begin
                    rem_reg <= CW'(1);
                end else begin
                    rem_reg <= shift_len[CW-1:0];
                end
            end else if (cmd.scan_en) begin
                pend_reg <= (rem_reg != '0);
                if (rem_reg != '0) begin
                    rem_reg <= rem_reg - CW'(1);
                end
            end
        end
    end

    // Walker addresses and captured input word.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            pos_reg   <= s_position;
            value_reg <= s_value;
        end
        if (cmd.scan_start) begin
            mode_reg     <= cmd.scan_mode;
            base_idx_reg <= pos_m1[AW-1:0];
            if (cmd.scan_mode == SCAN_FIND) begin
                idx_reg <= '0;
            end else if (cmd.scan_mode == SCAN_UP) begin
                idx_reg <= count_reg[AW-1:0] - AW'(1);
            end else begin
                idx_reg <= pos_m1[AW-1:0];
            end
        end else if (cmd.scan_en && (rem_reg != '0)) begin
            pend_idx_reg <= idx_reg;
            if (mode_reg == SCAN_UP) begin
                idx_reg <= idx_reg - AW'(1);
            end else begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // Result fields and output registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rval_reg <= '0;
            fpos_reg <= '0;
        end else if (cmd.scan_en) begin
            if (capture) begin
                rval_reg <= ram_rdata;
            end
            if (hit) begin
                fpos_reg <= fpos_ext[6:0];
            end
        end
        if (cmd.out_load) begin
            m_status_reg         <= cmd.status;
            m_result_value_reg   <= rval_reg;
            m_found_position_reg <= fpos_reg;
            m_list_length_reg    <= len_ext[6:0];
        end
    end

    assign m_status         = m_status_reg;
    assign m_result_value   = m_result_value_reg;
    assign m_found_position = m_found_position_reg;
    assign m_list_length    = m_list_length_reg;

    // The length never exceeds the capacity.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_ext <= CMPW'(DEPTH))
        else $error("list length beyond capacity");

    // The list only grows when it has room.
    a_grow_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count_inc |-> !stat.full)
        else $error("growth on a full list");

endmodule

/* hdl/positional_list_engine.sv */
// Top level of the positional list engine.
// Depends on ple_pkg, ple_ctrl, ple_dpath (which holds ple_ram).
//
// Usage: one input word (s_func, s_position, s_value) carries one operation
// on an ordered list of up to DEPTH signed 32-bit entries, positions from 1:
// clear, append, read, find, insert or delete. Each word yields exactly one
// result word (m_status, m_result_value, m_found_position, m_list_length).
// Both channels use valid/ready; a word moves when both are high.
// Clear, append, unused codes and errors go from the decode state straight
// to the finish state; read, find, insert and delete first run the walker.
// Find walks the store one entry per cycle; insert and delete shift one
// entry per cycle, and insert then writes the new entry. The single store
// read port paced by the walker sets this pace. One operation is in flight
// at a time; s_ready rises again once its result is in the output register,
// so a new word is taken while the previous result waits for m_ready. If the
// receiver stalls, a finished result waits until the output register frees.
// Reset (aresetn low, synchronous) empties the list and drops m_valid; the
// store contents are left as they are and are never read before written.
module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic [6:0]         s_position,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_result_value,
    output logic [6:0]         m_found_position,
    output logic [6:0]         m_list_length
);
    import ple_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencing of each operation.
    ple_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .stat   (stat)
    );

    // Store, counter, walker and result registers.
    ple_dpath #(
        .DEPTH(DEPTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_func          (s_func),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_status        (m_status),
        .m_result_value  (m_result_value),
        .m_found_position(m_found_position),
        .m_list_length   (m_list_length),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule
